/* rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants of the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
  localparam int AngBits       = 18;
  localparam int SincosStages  = 16;
  localparam int CompBits      = 16;
  localparam int AtanEntries   = 24;
  localparam int RunStages     = (SincosStages < AtanEntries) ? SincosStages : AtanEntries;
  localparam int ZBits         = 34;  // half angle, 2^-24 degree
  localparam int QBits         = 33;  // Q2.30 plus guard
  localparam logic signed [ZBits-1:0] Deg90  = 34'sd1509949440;
  localparam logic signed [ZBits-1:0] Deg180 = 34'sd3019898880;
  localparam logic signed [QBits-1:0] CordicGain = 33'sd652032874;

  typedef logic signed [QBits-1:0] q_t;
  typedef logic signed [ZBits-1:0] z_t;
  typedef logic signed [CompBits-1:0] comp_t;

  typedef struct packed {
    q_t   x;
    q_t   y;
    z_t   z;
    logic flip;
  } cordic_t;

  typedef struct packed {
    cordic_t roll;
    cordic_t pitch;
    cordic_t yaw;
  } triple_t;

  function automatic z_t atan_deg(input int i);
    case (i)
      0: atan_deg = 34'sd754974720;   1: atan_deg = 34'sd445687602;
      2: atan_deg = 34'sd235489088;   3: atan_deg = 34'sd119537938;
      4: atan_deg = 34'sd60000934;    5: atan_deg = 34'sd30029717;
      6: atan_deg = 34'sd15018523;    7: atan_deg = 34'sd7509720;
      8: atan_deg = 34'sd3754917;     9: atan_deg = 34'sd1877466;
      10: atan_deg = 34'sd938734;     11: atan_deg = 34'sd469367;
      12: atan_deg = 34'sd234683;     13: atan_deg = 34'sd117342;
      14: atan_deg = 34'sd58671;      15: atan_deg = 34'sd29335;
      16: atan_deg = 34'sd14668;      17: atan_deg = 34'sd7334;
      18: atan_deg = 34'sd3667;       19: atan_deg = 34'sd1833;
      20: atan_deg = 34'sd917;        21: atan_deg = 34'sd458;
      22: atan_deg = 34'sd229;        23: atan_deg = 34'sd115;
      default: atan_deg = '0;
    endcase
  endfunction

  // (a*b + 2^29) >>> 30
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [2*QBits-1:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    mulq = q_t'(p >>> 30);
  endfunction

  function automatic comp_t to_comp(input q_t v);
    localparam int Sh = 31 - CompBits;
    localparam logic signed [QBits+1:0] Lim = (QBits+2)'((64'sd1 <<< (CompBits-1)) - 1);
    logic signed [QBits+1:0] t;
    if (Sh > 0) t = ((QBits+2)'(v) + (QBits+2)'(64'sd1 <<< ((Sh > 0 ? Sh : 1) - 1))) >>> Sh;
    else if (Sh < 0) t = (QBits+2)'(v) <<< 1;
    else t = (QBits+2)'(v);
    if (t > Lim) t = Lim;
    if (t < -Lim) t = -Lim;
    to_comp = comp_t'(t);
  endfunction
endpackage
`default_nettype wire

/* rtl/e2q_if.sv */
// ----------------------------------------------------------------------------
// e2q_angle_if / e2q_quat_if
// Valid/ready channels carrying angle and quaternion beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface e2q_angle_if import e2q_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [AngBits-1:0] roll_deg;
  logic signed [AngBits-1:0] pitch_deg;
  logic signed [AngBits-1:0] yaw_deg;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface e2q_quat_if import e2q_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CompBits-1:0] quat_w;
  logic signed [CompBits-1:0] quat_x;
  logic signed [CompBits-1:0] quat_y;
  logic signed [CompBits-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

/* rtl/e2q_cell.sv */
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC rotation cell for three angles at once, registered output.
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_cell import e2q_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          en_i,
  input  wire    [4:0] stage_i,
  input  wire          valid_i,
  input  triple_t      data_i,
  output logic         valid_o,
  output triple_t      data_o
);
  triple_t data_d, data_q;
  logic    valid_q;

  function automatic cordic_t rot(input cordic_t c, input int i);
    cordic_t r;
    r = c;
    if (c.z >= 0) begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - atan_deg(i);
    end else begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + atan_deg(i);
    end
    return r;
  endfunction

  always_comb begin
    data_d.roll  = rot(data_i.roll, int'(stage_i));
    data_d.pitch = rot(data_i.pitch, int'(stage_i));
    data_d.yaw   = rot(data_i.yaw, int'(stage_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (Q10.8 degrees) to unit quaternion (Q1.15), pipelined.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// angle_i  | in  | roll_deg, pitch_deg, yaw_deg
// quat_o   | out | quat_w, quat_x, quat_y, quat_z
// One beat per cycle while the output is not stalled; the registered steps
// are fold, CORDIC cells, two product ranks and round. A stall at the output
// freezes the whole pipe; ready is high whenever the last stage is empty or
// being taken. Reset clears the valid bits only.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  e2q_angle_if.sink     angle_i,
  e2q_quat_if.source    quat_o
);
  logic en;
  assign en = !quat_o.valid || quat_o.ready;
  assign angle_i.ready = en;

  function automatic cordic_t fold(input logic signed [AngBits-1:0] a);
    cordic_t c;
    c.z = z_t'(a) <<< 15;
    c.flip = 1'b0;
    c.x = CordicGain;
    c.y = '0;
    if (c.z > Deg90) begin
      c.z = c.z - Deg180; c.flip = 1'b1;
    end else if (c.z < -Deg90) begin
      c.z = c.z + Deg180; c.flip = 1'b1;
    end
    return c;
  endfunction

  triple_t chain [RunStages+1];
  logic    vchain [RunStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vchain[0] <= 1'b0;
    else if (en) vchain[0] <= angle_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      chain[0].roll  <= fold(angle_i.roll_deg);
      chain[0].pitch <= fold(angle_i.pitch_deg);
      chain[0].yaw   <= fold(angle_i.yaw_deg);
    end
  end

  for (genvar g = 0; g < RunStages; g++) begin : g_cell
    e2q_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .stage_i(5'(g)),
      .valid_i(vchain[g]), .data_i(chain[g]),
      .valid_o(vchain[g+1]), .data_o(chain[g+1])
    );
  end

  // sign fix and first product rank
  q_t sr, cr, sp, cp, sy, cy;
  always_comb begin
    triple_t t;
    t  = chain[RunStages];
    sr = t.roll.flip  ? -t.roll.y  : t.roll.y;
    cr = t.roll.flip  ? -t.roll.x  : t.roll.x;
    sp = t.pitch.flip ? -t.pitch.y : t.pitch.y;
    cp = t.pitch.flip ? -t.pitch.x : t.pitch.x;
    sy = t.yaw.flip   ? -t.yaw.y   : t.yaw.y;
    cy = t.yaw.flip   ? -t.yaw.x   : t.yaw.x;
  end

  q_t crcp_q, srsp_q, srcp_q, crsp_q, sy_q, cy_q;
  logic v1_q, v2_q, v3_q;
  q_t p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
  comp_t w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= vchain[RunStages]; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crcp_q <= mulq(cr, cp); srsp_q <= mulq(sr, sp);
      srcp_q <= mulq(sr, cp); crsp_q <= mulq(cr, sp);
      sy_q <= sy; cy_q <= cy;
      p0_q <= mulq(crcp_q, cy_q); p1_q <= mulq(srsp_q, sy_q);
      p2_q <= mulq(srcp_q, cy_q); p3_q <= mulq(crsp_q, sy_q);
      p4_q <= mulq(crsp_q, cy_q); p5_q <= mulq(srcp_q, sy_q);
      p6_q <= mulq(crcp_q, sy_q); p7_q <= mulq(srsp_q, cy_q);
      w_q <= to_comp(p0_q + p1_q);
      x_q <= to_comp(p2_q - p3_q);
      y_q <= to_comp(p4_q + p5_q);
      z_q <= to_comp(p6_q - p7_q);
    end
  end

  assign quat_o.valid  = v3_q;
  assign quat_o.quat_w = w_q;
  assign quat_o.quat_x = x_q;
  assign quat_o.quat_y = y_q;
  assign quat_o.quat_z = z_q;
endmodule
`default_nettype wire

/* test/tb_euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Self-checking bench: random and directed angle beats, bit-exact CORDIC
// predictor, per-field comparison of quaternion beats, random stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_euler_to_quaternion;
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [AngBits-1:0] roll;
    logic signed [AngBits-1:0] pitch;
    logic signed [AngBits-1:0] yaw;
  } angles_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  e2q_angle_if angle_if ();
  e2q_quat_if  quat_if ();

  euler_to_quaternion i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .angle_i(angle_if.sink),
    .quat_o (quat_if.source)
  );

  always #1 clk_i = ~clk_i;

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      calm = 1'b0;
  bit      hold_off = 1'b0;
  bit      stim_done = 1'b0;

  localparam longint Gain = 64'sd652032874;
  localparam longint HalfQ = 64'sd536870912;
  localparam longint D90 = 64'sd1509949440;
  localparam longint D180 = 64'sd3019898880;

  function automatic longint atan_step(input int i);
    longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                      15018523, 7509720, 3754917, 1877466, 938734, 469367,
                      234683, 117342, 58671, 29335, 14668, 7334,
                      3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return (a * b + HalfQ) >>> 30;
  endfunction

  function automatic void half_sin_cos(input logic signed [AngBits-1:0] ang,
                                       output longint s, output longint c);
    longint h, x, y, nx;
    bit flip;
    h = longint'(ang) * 32768;
    flip = 1'b0;
    x = Gain;
    y = 0;
    if (h > D90) begin
      h -= D180;
      flip = 1'b1;
    end else if (h < -D90) begin
      h += D180;
      flip = 1'b1;
    end
    for (int i = 0; i < SincosStages && i < 24; i++) begin
      if (h >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        h -= atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        h += atan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic comp_t round_sat(input longint v);
    int sh;
    longint lim;
    sh = 31 - CompBits;
    lim = (64'sd1 <<< (CompBits - 1)) - 1;
    if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    else if (sh < 0) v = v * 2;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return comp_t'(v);
  endfunction

  function automatic quat_t euler_quat(input angles_t a);
    longint sr, cr, sp, cp, sy, cy, crcp, srsp, srcp, crsp;
    quat_t q;
    half_sin_cos(a.roll, sr, cr);
    half_sin_cos(a.pitch, sp, cp);
    half_sin_cos(a.yaw, sy, cy);
    crcp = round_mul(cr, cp);
    srsp = round_mul(sr, sp);
    srcp = round_mul(sr, cp);
    crsp = round_mul(cr, sp);
    q.w = round_sat(round_mul(crcp, cy) + round_mul(srsp, sy));
    q.x = round_sat(round_mul(srcp, cy) - round_mul(crsp, sy));
    q.y = round_sat(round_mul(crsp, cy) + round_mul(srcp, sy));
    q.z = round_sat(round_mul(crcp, sy) - round_mul(srsp, cy));
    return q;
  endfunction

  function automatic logic signed [AngBits-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return AngBits'($urandom);
      1: return AngBits'($signed($urandom_range(0, 40)) - 20 + 46080);
      2: return AngBits'($signed($urandom_range(0, 40)) - 20 - 46080);
      default: return AngBits'($signed($urandom_range(0, 184320)) - 92160);
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_if.valid <= 1'b0;
      angle_if.roll_deg <= '0;
      angle_if.pitch_deg <= '0;
      angle_if.yaw_deg <= '0;
    end else if (!angle_if.valid || angle_if.ready) begin
      if (pending_angles.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 21)) begin
        angle_if.valid <= 1'b1;
        angle_if.roll_deg <= pending_angles[0].roll;
        angle_if.pitch_deg <= pending_angles[0].pitch;
        angle_if.yaw_deg <= pending_angles[0].yaw;
        expected_quats.push_back(euler_quat(pending_angles.pop_front()));
      end else begin
        angle_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q;
    if (!rst_ni) begin
      quat_if.ready <= 1'b0;
    end else begin
      if (quat_if.valid && quat_if.ready) begin
        if (expected_quats.size() == 0) begin
          $error("unexpected quaternion beat");
          errors++;
        end else begin
          exp_q = expected_quats.pop_front();
          if (quat_if.quat_w !== exp_q.w) begin
            $error("quat_w exp %0d got %0d", exp_q.w, quat_if.quat_w);
            errors++;
          end
          if (quat_if.quat_x !== exp_q.x) begin
            $error("quat_x exp %0d got %0d", exp_q.x, quat_if.quat_x);
            errors++;
          end
          if (quat_if.quat_y !== exp_q.y) begin
            $error("quat_y exp %0d got %0d", exp_q.y, quat_if.quat_y);
            errors++;
          end
          if (quat_if.quat_z !== exp_q.z) begin
            $error("quat_z exp %0d got %0d", exp_q.z, quat_if.quat_z);
            errors++;
          end
        end
      end
      quat_if.ready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    angles_t a;
    logic signed [AngBits-1:0] corner[8] = '{18'sd0, 18'sd92160, -18'sd92160, 18'sd46080,
                                              -18'sd46080, 18'sd46081, 18'sd131071,
                                              -18'sd131072};
    angle_if.valid = 1'b0;
    angle_if.roll_deg = '0;
    angle_if.pitch_deg = '0;
    angle_if.yaw_deg = '0;
    quat_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      a.roll = corner[i];
      a.pitch = corner[(i + 3) % 8];
      a.yaw = corner[(i + 5) % 8];
      pending_angles.push_back(a);
    end
    for (int i = 0; i < 8; i++) begin
      a = '{corner[i], corner[i], corner[i]};
      pending_angles.push_back(a);
    end
    for (int i = 0; i < 600; i++) begin
      a = '{rand_angle(), rand_angle(), rand_angle()};
      pending_angles.push_back(a);
    end
    wait (pending_angles.size() == 0);
    @(posedge clk_i);
    hold_off <= 1'b1;
    wait (expected_quats.size() == 0);
    @(posedge clk_i);
    hold_off <= 1'b0;
    calm <= 1'b1;
    for (int i = 0; i < 400; i++) begin
      a = '{rand_angle(), rand_angle(), rand_angle()};
      pending_angles.push_back(a);
    end
    wait (pending_angles.size() == 0);
    @(posedge clk_i);
    calm <= 1'b0;
    for (int i = 0; i < 734; i++) begin
      a = '{rand_angle(), rand_angle(), rand_angle()};
      pending_angles.push_back(a);
    end
    wait (pending_angles.size() == 0);
    wait (expected_quats.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* euler_to_quaternion.f */
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_cell.sv
rtl/euler_to_quaternion.sv
test/tb_euler_to_quaternion.sv
